FILE: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and widths of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W   = 2;
    localparam int POS_W      = 5;
    localparam int IO_DATA_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_SORT   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_SORT   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t kind;
        logic     phase;
        logic     is_signed;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_SORT = 2'b10
    } fsm_t;

endpackage

FILE: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH words addressed by position, kept in a row of
// cells, with insert, remove, read and ascending sort.
// ----------------------------------------------------------------------------
// Insert, remove and read: the cell row shifts or is tapped in the cycle of
// the transfer and the result is registered for the next cycle. Sort runs
// an odd-even compare-swap over the row, one round per cycle, for as many
// rounds as there are stored words, holding s_tready low until its result is
// loaded. The next input is taken only when the result register
// is empty or its result leaves on the master side in the same cycle.
module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_data,   // compare_signed
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] opcode, [6:2] position, [38:7] data_in, [39] zero
    input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] data_out, [33:32] status, [38:34] list_length, [39] zero
    output logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ple_pkg::op_t                  opcode;
    logic [ple_pkg::POS_W-1:0]     position;
    logic [ple_pkg::IO_DATA_W-1:0] data_in;
    logic [DATA_WIDTH-1:0]         word_in;
    logic [DATA_WIDTH-1:0]         words [DEPTH];
    logic [DEPTH-1:0]              swaps;
    logic [DATA_WIDTH-1:0]         rd_word;
    ple_pkg::cell_cmd_t            cmd;
    logic [IDX_W-1:0]              at;
    logic [CNT_W-1:0]              count;
    logic [ple_pkg::IO_DATA_W-1:0] data_out;
    ple_pkg::status_t              status;
    logic [ple_pkg::LEN_W-1:0]     list_length;

    assign opcode   = ple_pkg::op_t'(s_tdata[1:0]);
    assign position = s_tdata[6:2];
    assign data_in  = s_tdata[38:7];
    assign word_in  = DATA_WIDTH'(data_in);
    assign rd_word  = words[IDX_W'(position)];
    assign swaps[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] prev_word;
            logic [DATA_WIDTH-1:0] next_word;
            logic                  swap_out;

            if (i == 0)
            begin : g_first
                assign prev_word = words[0];
            end
            else
            begin : g_mid_prev
                assign prev_word = words[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_word = words[DEPTH-1];
            end
            else
            begin : g_mid_next
                assign next_word  = words[i+1];
                assign swaps[i+1] = swap_out;
            end

            ple_cell #(
                .DEPTH      (DEPTH),
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (i)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .at        (at),
                .count     (count),
                .word_in   (word_in),
                .prev_word (prev_word),
                .next_word (next_word),
                .swap_in   (swaps[i]),
                .swap_out  (swap_out),
                .word      (words[i])
            );
        end
    endgenerate

    ple_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .opcode      (opcode),
        .position    (position),
        .rd_word     (rd_word),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .data_out    (data_out),
        .status      (status),
        .list_length (list_length),
        .cmd         (cmd),
        .at          (at),
        .count       (count)
    );

    assign m_tdata = {1'b0, list_length, status, data_out};

endmodule

FILE: hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a word, shifts with its neighbors on insert and
// remove, and compare-swaps with its right neighbor during sort.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  ple_pkg::cell_cmd_t    cmd,
    input  logic [IDX_W-1:0]      at,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] word_in,
    input  logic [DATA_WIDTH-1:0] prev_word,
    input  logic [DATA_WIDTH-1:0] next_word,
    input  logic                  swap_in,
    output logic                  swap_out,
    output logic [DATA_WIDTH-1:0] word
);

    localparam logic [IDX_W-1:0]      POS      = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0]      NEXT_POS = CNT_W'(INDEX + 1);
    localparam logic                  PARITY   = 1'(INDEX % 2);
    localparam logic [DATA_WIDTH-1:0] SIGN     = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic [DATA_WIDTH-1:0] key_self;
    logic [DATA_WIDTH-1:0] key_next;
    logic                  greater;
    logic                  lower;

    always_comb
    begin
        key_self = cmd.is_signed ? (word_reg ^ SIGN) : word_reg;
        key_next = cmd.is_signed ? (next_word ^ SIGN) : next_word;
        greater  = key_self > key_next;
        lower    = (cmd.phase == PARITY) && (count > NEXT_POS);
        swap_out = (cmd.kind == ple_pkg::CELL_SORT) && lower && greater;
    end

    always_comb
    begin
        word_next = word_reg;
        case (cmd.kind)
            ple_pkg::CELL_INSERT:
            begin
                if (POS > at)
                    word_next = prev_word;
                else if (POS == at)
                    word_next = word_in;
            end
            ple_pkg::CELL_REMOVE:
            begin
                if (POS >= at)
                    word_next = next_word;
            end
            ple_pkg::CELL_SORT:
            begin
                if (swap_out)
                    word_next = next_word;
                else if (swap_in)
                    word_next = prev_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

FILE: hw/rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer of the list: length, sort rounds, stream handshake and the
// result register.
// ----------------------------------------------------------------------------
module ple_ctrl #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int CMP_W     = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ple_pkg::op_t                  opcode,
    input  logic [ple_pkg::POS_W-1:0]     position,
    input  logic [DATA_WIDTH-1:0]         rd_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ple_pkg::IO_DATA_W-1:0] data_out,
    output ple_pkg::status_t              status,
    output logic [ple_pkg::LEN_W-1:0]     list_length,
    output ple_pkg::cell_cmd_t            cmd,
    output logic [IDX_W-1:0]              at,
    output logic [CNT_W-1:0]              count
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    ple_pkg::fsm_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] round_reg, round_next;
    logic             phase_reg, phase_next;
    logic             signed_reg;
    logic             valid_reg, valid_next;
    logic [ple_pkg::IO_DATA_W-1:0] data_reg, data_next;
    ple_pkg::status_t status_reg, status_next;
    logic [ple_pkg::LEN_W-1:0] len_reg, len_next;
    logic             out_free;
    logic             accept;
    logic             in_range;
    logic             full;
    logic             load;

    always_comb
    begin
        out_free = !valid_reg || out_ready;
        in_ready = (state_reg == ple_pkg::FSM_IDLE) && out_free;
        accept   = in_valid && in_ready;
        in_range = CMP_W'(position) < CMP_W'(count_reg);
        full     = count_reg == FULL;

        state_next  = state_reg;
        count_next  = count_reg;
        round_next  = round_reg;
        phase_next  = phase_reg;
        data_next   = data_reg;
        status_next = status_reg;
        len_next    = len_reg;
        load        = 1'b0;
        at          = IDX_W'(position);
        cmd.kind      = ple_pkg::CELL_HOLD;
        cmd.phase     = phase_reg;
        cmd.is_signed = signed_reg;

        case (state_reg)
            ple_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    data_next   = '0;
                    status_next = ple_pkg::STAT_OK;
                    case (opcode)
                        ple_pkg::OP_INSERT:
                        begin
                            load = 1'b1;
                            if (full)
                                status_next = ple_pkg::STAT_FULL;
                            else
                            begin
                                cmd.kind   = ple_pkg::CELL_INSERT;
                                at         = in_range ? IDX_W'(position) : IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ple_pkg::OP_REMOVE:
                        begin
                            load = 1'b1;
                            if (in_range)
                            begin
                                cmd.kind   = ple_pkg::CELL_REMOVE;
                                data_next  = ple_pkg::IO_DATA_W'(rd_word);
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                                status_next = ple_pkg::STAT_RANGE;
                        end
                        ple_pkg::OP_READ:
                        begin
                            load = 1'b1;
                            if (in_range)
                                data_next = ple_pkg::IO_DATA_W'(rd_word);
                            else
                                status_next = ple_pkg::STAT_RANGE;
                        end
                        default:
                        begin
                            state_next = ple_pkg::FSM_SORT;
                            round_next = count_reg;
                            phase_next = 1'b0;
                        end
                    endcase
                    len_next = ple_pkg::LEN_W'(count_next);
                end
            end
            ple_pkg::FSM_SORT:
            begin
                if (round_reg != '0)
                begin
                    cmd.kind   = ple_pkg::CELL_SORT;
                    round_next = round_reg - CNT_W'(1);
                    phase_next = !phase_reg;
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ple_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::FSM_IDLE;
            end
        endcase

        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ple_pkg::FSM_IDLE;
            count_reg  <= '0;
            round_reg  <= '0;
            phase_reg  <= 1'b0;
            signed_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            if (cfg_we)
                signed_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
        len_reg    <= len_next;
    end

    assign out_valid   = valid_reg;
    assign data_out    = data_reg;
    assign status      = status_reg;
    assign list_length = len_reg;
    assign count       = count_reg;

endmodule

FILE: hw/rtl/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [ple_pkg::OPCODE_W-1:0] SORT_CODE = ple_pkg::OP_SORT;
    localparam logic [ple_pkg::STATUS_W-1:0] BAD_CODE  = 2'd3;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while result blocked");

    a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[1:0] != SORT_CODE) |=> m_tvalid)
        else $error("result missing after list transfer");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:32] != BAD_CODE))
        else $error("invalid status code");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && DEPTH < 32) |-> (32'(m_tdata[38:34]) <= 32'(DEPTH)))
        else $error("length beyond depth");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/positional_list_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking bench for the positional list engine. A clocked driver sends
// list commands from a backlog on the input stream. A clocked monitor keeps
// its own copy of the list and predicts the reply of every command it sees
// transfer, then compares each reply on the output stream against the oldest
// prediction. A short directed sequence opens the run. Randomized phases
// follow, with fill, mixed and drain mixes, both sort compares and varying
// stalls on either stream.
// ----------------------------------------------------------------------------
module positional_list_engine_test;

    localparam int LIST_DEPTH = ple_pkg::DEPTH_DEF;

    typedef struct packed {
        logic [31:0]  word;
        logic [4:0]   pos;
        ple_pkg::op_t op;
    } list_cmd_t;

    typedef struct packed {
        logic [4:0]       length;
        ple_pkg::status_t status;
        logic [31:0]      word;
    } list_reply_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          cfg_we   = 1'b0;
    logic                          cfg_data = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ple_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ple_pkg::M_TDATA_W-1:0] m_tdata;

    list_cmd_t   cmd_backlog[$];
    list_reply_t pending_replies[$];

    logic [31:0] list_words[LIST_DEPTH];
    int          list_len         = 0;
    logic        sort_signed      = 1'b0;
    int          planned_len      = 0;
    int          sender_idle_pct  = 37;
    int          recv_idle_pct    = 80;
    int          mismatch_count   = 0;
    bit          input_taken      = 1'b0;

    positional_list_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        rst_n = 1'b0;
        fork
            forever #2 clk = ~clk;
            begin
                repeat (9) @(posedge clk);
                @(negedge clk);
                rst_n = 1'b1;
            end
        join
    end

    initial
    begin
        #(2_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit sorts_after(logic [31:0] a, logic [31:0] b);
        if (sort_signed)
            return $signed(a) > $signed(b);
        return a > b;
    endfunction

    function automatic list_reply_t apply_to_list(list_cmd_t cmd);
        list_reply_t rep;
        logic [31:0] key;
        int          at;
        int          j;
        rep.word   = '0;
        rep.status = ple_pkg::STAT_OK;
        case (cmd.op)
            ple_pkg::OP_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    rep.status = ple_pkg::STAT_FULL;
                else
                begin
                    at = (cmd.pos >= list_len) ? list_len : int'(cmd.pos);
                    for (int k = list_len; k > at; k--)
                        list_words[k] = list_words[k-1];
                    list_words[at] = cmd.word;
                    list_len++;
                end
            end
            ple_pkg::OP_REMOVE:
            begin
                if (cmd.pos >= list_len)
                    rep.status = ple_pkg::STAT_RANGE;
                else
                begin
                    rep.word = list_words[cmd.pos];
                    for (int k = cmd.pos; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
            ple_pkg::OP_READ:
            begin
                if (cmd.pos >= list_len)
                    rep.status = ple_pkg::STAT_RANGE;
                else
                    rep.word = list_words[cmd.pos];
            end
            default:
            begin
                for (int i = 1; i < list_len; i++)
                begin
                    key = list_words[i];
                    j   = i;
                    while (j > 0 && sorts_after(list_words[j-1], key))
                    begin
                        list_words[j] = list_words[j-1];
                        j--;
                    end
                    list_words[j] = key;
                end
            end
        endcase
        rep.length = list_len[4:0];
        return rep;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %0s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || input_taken)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                s_tdata  <= {1'b0, cmd_backlog.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        list_reply_t got;
        list_reply_t want;
        input_taken = rst_n && s_tvalid && s_tready;
        if (rst_n && cfg_we)
            sort_signed = cfg_data;
        if (input_taken)
            pending_replies.push_back(apply_to_list(list_cmd_t'(s_tdata[38:0])));
        if (rst_n && m_tvalid && m_tready)
        begin
            got = list_reply_t'(m_tdata[38:0]);
            if (pending_replies.size() == 0)
                report_mismatch("unexpected reply", m_tdata[31:0], 32'h0);
            else
            begin
                want = pending_replies.pop_front();
                if (got.word !== want.word)
                    report_mismatch("data_out", got.word, want.word);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.length !== want.length)
                    report_mismatch("list_length", 32'(got.length), 32'(want.length));
            end
        end
    end

    function automatic void queue_cmd(ple_pkg::op_t op, int pos, logic [31:0] word);
        list_cmd_t cmd;
        cmd.op   = op;
        cmd.pos  = pos[4:0];
        cmd.word = word;
        cmd_backlog.push_back(cmd);
        if (op == ple_pkg::OP_INSERT && planned_len < LIST_DEPTH)
            planned_len++;
        else if (op == ple_pkg::OP_REMOVE && cmd.pos < planned_len)
            planned_len--;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(15));
            5:       return {28'hFFF_FFFF, 4'($urandom_range(15))};
            default: return $urandom;
        endcase
    endfunction

    // insert_pct and remove_pct set the mix; the rest splits into reads and sorts
    task automatic queue_random(int n, int insert_pct, int remove_pct);
        int           r;
        int           pos;
        ple_pkg::op_t op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < insert_pct)
                op = ple_pkg::OP_INSERT;
            else if (r < insert_pct + remove_pct)
                op = ple_pkg::OP_REMOVE;
            else if (r < 88)
                op = ple_pkg::OP_READ;
            else
                op = ple_pkg::OP_SORT;
            if ($urandom_range(3) == 0)
                pos = $urandom_range(31);
            else if (op == ple_pkg::OP_INSERT)
                pos = $urandom_range(planned_len);
            else
                pos = (planned_len > 0) ? $urandom_range(planned_len - 1) : 0;
            queue_cmd(op, pos, pick_word());
        end
    endtask

    task automatic wait_for_drain();
        while (cmd_backlog.size() != 0 || s_tvalid || pending_replies.size() != 0)
            @(posedge clk);
        repeat (24) @(negedge clk);
    endtask

    task automatic write_compare(logic value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(logic signed_cmp);
        write_compare(signed_cmp);
        queue_random(150, 60, 15);
        wait_for_drain();
        queue_random(200, 35, 25);
        wait_for_drain();
        queue_random(130, 20, 50);
        wait_for_drain();
        queue_random(150, 35, 25);
        wait_for_drain();
    endtask

    initial
    begin
        while (!rst_n)
            @(negedge clk);
        write_compare(1'b0);

        queue_cmd(ple_pkg::OP_READ,   0,  $urandom);
        queue_cmd(ple_pkg::OP_REMOVE, 0,  $urandom);
        queue_cmd(ple_pkg::OP_SORT,   31, 32'hFFFF_FFFF);
        queue_cmd(ple_pkg::OP_INSERT, 31, 32'hFFFF_FFFF);
        queue_cmd(ple_pkg::OP_SORT,   0,  $urandom);
        queue_cmd(ple_pkg::OP_INSERT, 0,  32'h0000_0000);
        queue_cmd(ple_pkg::OP_INSERT, 1,  32'h8000_0000);
        queue_cmd(ple_pkg::OP_INSERT, 5,  32'h7FFF_FFFF);
        queue_cmd(ple_pkg::OP_READ,   3,  $urandom);
        queue_cmd(ple_pkg::OP_READ,   4,  $urandom);
        queue_cmd(ple_pkg::OP_READ,   31, $urandom);
        queue_cmd(ple_pkg::OP_SORT,   16, $urandom);
        queue_cmd(ple_pkg::OP_READ,   0,  $urandom);
        queue_cmd(ple_pkg::OP_READ,   3,  $urandom);
        queue_cmd(ple_pkg::OP_REMOVE, 1,  $urandom);
        queue_cmd(ple_pkg::OP_REMOVE, 2,  $urandom);
        queue_cmd(ple_pkg::OP_REMOVE, 9,  $urandom);
        wait_for_drain();

        write_compare(1'b1);
        queue_cmd(ple_pkg::OP_INSERT, 0,  32'h8000_0000);
        queue_cmd(ple_pkg::OP_INSERT, 16, 32'h7FFF_FFFF);
        queue_cmd(ple_pkg::OP_SORT,   0,  $urandom);
        queue_cmd(ple_pkg::OP_READ,   0,  $urandom);
        wait_for_drain();

        run_phase(1'b1);
        sender_idle_pct = 80;
        recv_idle_pct   = 37;
        run_phase(1'b0);
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        run_phase(1'b1);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine.sv
hw/rtl/ple_checker.sv
tb/positional_list_engine_test.sv
